// ===== hdl/bsoc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsoc_pkg
// Shared types and constants for the battery state-of-charge block: the
// open-circuit-voltage table, per-segment slopes and register indexes.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  localparam int unsigned NumPoints = 21;
  localparam int unsigned NumSegs   = NumPoints - 1;

  localparam logic [6:0] PctFull   = 7'd100;
  localparam logic [6:0] PctCapped = 7'd99;
  localparam logic [6:0] PctEmpty  = 7'd0;

  // table points, highest voltage first
  localparam logic [12:0] SOC_MV [NumPoints] = '{
    13'd4200, 13'd4150, 13'd4110, 13'd4070, 13'd4030, 13'd3990, 13'd3950,
    13'd3910, 13'd3870, 13'd3830, 13'd3790, 13'd3750, 13'd3710, 13'd3670,
    13'd3630, 13'd3590, 13'd3550, 13'd3500, 13'd3440, 13'd3360, 13'd3300
  };

  localparam logic [6:0] SOC_PCT [NumPoints] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd65, 7'd60, 7'd55,
    7'd50, 7'd45, 7'd40, 7'd35, 7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5,
    7'd0
  };

  // every segment rises by 5 %, so each percent step is span / 5 mV
  localparam logic [4:0] SEG_STEP [NumSegs] = '{
    5'd10, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8,
    5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd10, 5'd12, 5'd16, 5'd12
  };

  typedef enum logic {
    REG_FULL_MV = 1'b0,
    REG_MARGIN  = 1'b1
  } reg_idx_t;

  // gauge side-band carried alongside the voltage pipeline
  typedef struct packed {
    logic       gauge_bad;
    logic       distrust;
    logic       charging;
    logic [6:0] gauge;
  } fuse_t;

endpackage

// ===== hdl/bsoc_volt_est.sv =====
// ----------------------------------------------------------------------------
// bsoc_volt_est
// Three-stage voltage-to-percent interpolator: segment search, offset and
// slope lookup, then quotient by threshold compares and saturation.
// ----------------------------------------------------------------------------
module bsoc_volt_est
  import bsoc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [12:0] cell_mv,
  output logic [6:0]  est
);

  // stage 1
  logic [12:0] mv1;
  logic [4:0]  seg1;
  logic        top1;
  logic        bot1;
  logic [4:0]  seg_next;

  // stage 2
  logic [6:0] d2;
  logic [4:0] step2;
  logic [6:0] base2;
  logic       top2;
  logic       bot2;

  logic [12:0] lo_mv;
  logic [6:0]  q_sum;
  logic [6:0]  s1;
  logic [6:0]  s2;
  logic [6:0]  s3;
  logic [6:0]  s4;
  logic [6:0]  est_next;

  // segment = count of inner points above the reading
  always_comb begin
    seg_next = '0;
    for (int j = 1; j < NumSegs; j++) begin
      seg_next = seg_next + 5'(cell_mv < SOC_MV[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mv1  <= cell_mv;
      seg1 <= seg_next;
      top1 <= cell_mv >= SOC_MV[0];
      bot1 <= cell_mv <= SOC_MV[NumPoints-1];
    end
  end

  assign lo_mv = SOC_MV[seg1 + 5'd1];

  always_ff @(posedge clk) begin
    if (en) begin
      d2    <= 7'(mv1 - lo_mv);
      step2 <= SEG_STEP[seg1];
      base2 <= SOC_PCT[seg1 + 5'd1];
      top2  <= top1;
      bot2  <= bot1;
    end
  end

  always_comb begin
    s1 = {2'b00, step2};
    s2 = {step2, 1'b0} & 7'h7f;
    s3 = s1 + s2;
    s4 = {step2, 2'b00};
    q_sum = 7'(d2 >= s1) + 7'(d2 >= s2) + 7'(d2 >= s3) + 7'(d2 >= s4);
    if (top2) begin
      est_next = PctFull;
    end else if (bot2) begin
      est_next = PctEmpty;
    end else begin
      est_next = base2 + q_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est <= est_next;
    end
  end

endmodule

// ===== hdl/battery_soc_from_voltage.sv =====
// ----------------------------------------------------------------------------
// battery_soc_from_voltage
// Resolves a battery percent from cell voltage, fuel-gauge reading and the
// charging flag, with a piecewise linear open-circuit-voltage estimate.
// ----------------------------------------------------------------------------
// Four-stage pipeline taking one beat per clock while it is not stalled. The
// pipeline stalls as a whole while the output register holds an untaken
// result; in_ready follows out_ready for that reason. Stages: segment
// search, table lookup, quotient and clamp, gauge fusion into the output
// register.
module battery_soc_from_voltage
  import bsoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [12:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [12:0]       cell_mv,
  input  logic signed [7:0] fuel_pct,
  input  logic              is_charging,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        percent
);

  logic [12:0] full_voltage_mv;
  logic [6:0]  charge_margin_pct;

  logic  en;
  logic  v1;
  logic  v2;
  logic  v3;
  fuse_t side_next;
  fuse_t side1;
  fuse_t side2;
  fuse_t side3;
  logic [6:0] est;
  logic [7:0] cap_sum;
  logic [6:0] cap;
  logic [6:0] percent_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_voltage_mv   <= 13'd4180;
      charge_margin_pct <= 7'd5;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_FULL_MV: full_voltage_mv   <= cfg_wdata;
        REG_MARGIN:  charge_margin_pct <= cfg_wdata[6:0];
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    side_next.gauge_bad = $unsigned(fuel_pct) > 8'd100;
    side_next.distrust  = ($unsigned(fuel_pct) == 8'd100) && (cell_mv != '0)
                          && (cell_mv < full_voltage_mv);
    side_next.charging  = is_charging;
    side_next.gauge     = fuel_pct[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side_next;
      side2 <= side1;
      side3 <= side2;
    end
  end

  bsoc_volt_est u_est (
    .clk     (clk),
    .en      (en),
    .cell_mv (cell_mv),
    .est     (est)
  );

  always_comb begin
    cap_sum = {1'b0, est} + {1'b0, charge_margin_pct};
    cap     = (cap_sum > {1'b0, PctFull}) ? PctFull : cap_sum[6:0];
    if (side3.gauge_bad) begin
      percent_next = est;
    end else if (side3.distrust) begin
      percent_next = (est < PctFull) ? est : PctCapped;
    end else if (side3.charging) begin
      percent_next = (side3.gauge < cap) ? side3.gauge : cap;
    end else begin
      percent_next = est;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      percent <= percent_next;
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> percent <= PctFull)
    else $error("percent above full scale");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(v1) && $stable(v2) && $stable(v3))
    else $error("pipeline moved during stall");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_ready && in_valid |=> v1)
    else $error("accepted beat lost at stage one");

endmodule

// ===== test/battery_soc_checker.sv =====
// ----------------------------------------------------------------------------
// battery_soc_checker
// Watches the register port and both channels of the state-of-charge block.
// Each accepted reading is resolved to a percent with a local copy of the
// voltage table and registers, and each percent beat is compared in order.
// ----------------------------------------------------------------------------
module battery_soc_checker
  import bsoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [12:0]       cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [12:0]       cell_mv,
  input  logic signed [7:0] fuel_pct,
  input  logic              is_charging,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [6:0]        percent,
  output int                n_fail,
  output int                n_pending
);

  localparam int LastPt      = 20;
  localparam int SegRise     = 5;
  localparam int GaugeMax    = 100;
  localparam int PctCap      = 99;
  localparam int FullMvReset = 4180;
  localparam int MarginReset = 5;

  localparam int OcvMv [21] = '{
    4200, 4150, 4110, 4070, 4030, 3990, 3950, 3910, 3870, 3830, 3790,
    3750, 3710, 3670, 3630, 3590, 3550, 3500, 3440, 3360, 3300
  };
  localparam int OcvPct [21] = '{
    100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
    45, 40, 35, 30, 25, 20, 15, 10, 5, 0
  };

  logic [12:0] full_mv;
  logic [6:0]  margin;
  logic [6:0]  percent_due [$];

  function automatic int ocv_estimate(input logic [12:0] mv);
    int v;
    int est;
    v   = int'(mv);
    est = 0;
    if (v >= OcvMv[0]) begin
      est = GaugeMax;
    end else if (v > OcvMv[LastPt]) begin
      for (int i = 0; i < LastPt; i++) begin
        if (v <= OcvMv[i] && v >= OcvMv[i+1]) begin
          est = OcvPct[i+1] + (SegRise * (v - OcvMv[i+1])) / (OcvMv[i] - OcvMv[i+1]);
          break;
        end
      end
    end
    return est;
  endfunction

  function automatic logic [6:0] resolve_percent(input logic [12:0] mv,
                                                 input logic [7:0]  gauge,
                                                 input logic        charging,
                                                 input logic [12:0] full_now,
                                                 input logic [6:0]  margin_now);
    int est;
    int cap;
    int code;
    est  = ocv_estimate(mv);
    code = int'(gauge);
    // negative codes read as 128..255 here
    if (code > GaugeMax) return est[6:0];
    if (code == GaugeMax && mv != 0 && mv < full_now) begin
      return (est < GaugeMax) ? est[6:0] : PctCap[6:0];
    end
    if (charging) begin
      cap = est + int'(margin_now);
      if (cap > GaugeMax) cap = GaugeMax;
      return (code < cap) ? code[6:0] : cap[6:0];
    end
    return est[6:0];
  endfunction

  always @(posedge clk) begin
    logic [6:0] want;
    if (rst) begin
      full_mv <= FullMvReset[12:0];
      margin  <= MarginReset[6:0];
      percent_due.delete();
      n_pending <= 0;
      n_fail    <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_FULL_MV: full_mv <= cfg_wdata;
          REG_MARGIN:  margin  <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (percent_due.size() == 0) begin
          $error("percent: expected none, got %0d", percent);
          n_fail <= n_fail + 1;
        end else begin
          want = percent_due.pop_front();
          if (percent !== want) begin
            $error("percent: expected %0d, got %0d", want, percent);
            n_fail <= n_fail + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        percent_due.push_back(resolve_percent(cell_mv, fuel_pct, is_charging,
                                              full_mv, margin));
      end
      n_pending <= percent_due.size();
    end
  end

endmodule

// ===== test/battery_soc_from_voltage_tb.sv =====
// ----------------------------------------------------------------------------
// battery_soc_from_voltage_tb
// Drives voltage, gauge and charging readings into the state-of-charge block
// in random bursts under a stalling receiver, across several register
// settings, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module battery_soc_from_voltage_tb;
  import bsoc_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int PhaseBeats  = 260;
  localparam int SettleTicks = 8;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN,
    RX_STARVED
  } rx_mode_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_we      = 1'b0;
  logic              cfg_addr    = 1'b0;
  logic [12:0]       cfg_wdata   = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [12:0]       cell_mv     = '0;
  logic signed [7:0] fuel_pct    = '0;
  logic              is_charging = 1'b0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [6:0]        percent;

  int       n_fail;
  int       n_pending;
  int       cycles    = 0;
  int       cur_full  = 4180;
  rx_mode_t rx_mode   = RX_OPEN;
  int       rx_left   = 0;

  battery_soc_from_voltage u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_mv    (cell_mv),
    .fuel_pct   (fuel_pct),
    .is_charging(is_charging),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .percent    (percent)
  );

  battery_soc_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_mv    (cell_mv),
    .fuel_pct   (fuel_pct),
    .is_charging(is_charging),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .percent    (percent),
    .n_fail     (n_fail),
    .n_pending  (n_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver back-pressure; the mode is redrawn whenever rx_left runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: out_ready <= (rx_left % 3 != 0);
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic int pick_mv(input int near);
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      v = $urandom_range(3250, 4250);
    end else if (sel < 70) begin
      v = int'(SOC_MV[$urandom_range(0, NumPoints - 1)]) + int'($urandom_range(0, 2)) - 1;
    end else if (sel < 80) begin
      v = near + int'($urandom_range(0, 4)) - 2;
    end else begin
      v = $urandom_range(0, 8191);
    end
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    return v;
  endfunction

  function automatic int pick_gauge();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return $urandom_range(0, 100);
    if (sel < 65) return 100;
    return $urandom_range(0, 255);
  endfunction

  task automatic send_reading(input int mv, input int gauge, input int charging);
    in_valid    <= 1'b1;
    cell_mv     <= mv[12:0];
    fuel_pct    <= gauge[7:0];
    is_charging <= charging[0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data[12:0];
    if (idx == REG_FULL_MV) cur_full = data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_readings(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      if ($urandom_range(0, 4) == 0) burst = $urandom_range(40, 80);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_reading(pick_mv(cur_full), pick_gauge(), $urandom_range(0, 1));
        left--;
      end
      if (left > 0) begin
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) begin
          drain_results();
        end else if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: full 4180 mV, margin 5 %
    send_reading(0, 0, 0);
    send_reading(8191, 127, 1);
    send_reading(4200, -128, 0);
    send_reading(4179, 100, 0);     // gauge full, below full voltage
    send_reading(4180, 100, 1);     // gauge full, at full voltage
    send_reading(0, 100, 1);        // gauge full at zero volts is trusted
    send_reading(3300, 50, 1);
    send_reading(3301, 3, 1);
    send_reading(3360, 101, 0);
    send_reading(3500, -1, 1);
    send_reading(4150, 95, 0);
    send_reading(3910, 80, 1);      // gauge above estimate plus margin
    send_reading(3705, 37, 1);
    send_reading(4100, 100, 0);
    send_reading(4201, 100, 0);
    send_reading(3299, 0, 1);
    send_reading(4060, 90, 1);
    send_reading(3400, 7, 0);
    send_reading(3800, 100, 1);
    send_reading(4210, 99, 1);      // margin sum clipped at 100
    send_reading(13'h1555, 8'h55, 0);
    send_reading(13'h0AAA, 8'hAA, 1);
    drain_results();

    random_readings(PhaseBeats);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_FULL_MV, 0);
          write_reg(REG_MARGIN, 0);
        end
        1: begin
          write_reg(REG_FULL_MV, 8191);
          write_reg(REG_MARGIN, 8191);
        end
        2: begin
          write_reg(REG_FULL_MV, 4180);
          write_reg(REG_MARGIN, 100);
        end
        3: begin
          write_reg(REG_FULL_MV, $urandom_range(3300, 4300));
          write_reg(REG_MARGIN, $urandom_range(0, 8191));
        end
        default: begin
          write_reg(REG_FULL_MV, 4200);
          write_reg(REG_MARGIN, 1);
        end
      endcase
      random_readings(PhaseBeats);
    end

    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bsoc_pkg.sv
hdl/bsoc_volt_est.sv
hdl/battery_soc_from_voltage.sv
test/battery_soc_checker.sv
test/battery_soc_from_voltage_tb.sv
